/* hw/rtl/grid_bucket_radius_query_macros.svh */
// Assertion helpers for the grid bucket query block
`ifndef GRID_BUCKET_RADIUS_QUERY_MACROS_SVH
`define GRID_BUCKET_RADIUS_QUERY_MACROS_SVH

// checked only outside reset
`define GBRQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define GBRQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/gbrq_pkg.sv */
`default_nettype none
package gbrq_pkg;

    localparam int GRID_DIM   = 64;
    localparam int CELL_W     = $clog2(GRID_DIM);
    localparam int CNT_W      = CELL_W + 1;
    localparam int POOL_SIZE  = 1024;
    localparam int IDX_W      = $clog2(POOL_SIZE);
    localparam int ENT_W      = IDX_W + 1;
    localparam int HEAD_AW    = 1 + 2 * CELL_W;
    localparam int HEAD_DEPTH = 2 ** HEAD_AW;
    localparam int LINK_AW    = 1 + IDX_W;
    localparam int LINK_DEPTH = 2 ** LINK_AW;

    localparam int POS_W      = 32;
    localparam int PAD_W      = 31;
    localparam int PADS_W     = 33;
    localparam int CPU_W      = 24;
    localparam int FRAC       = 24;
    localparam int D_W        = 35;
    localparam int DL_W       = 17;
    localparam int DH_W       = D_W - 1 - DL_W;
    localparam int PROD_W     = DL_W + CPU_W;
    localparam int SAT_LO     = FRAC + CELL_W - DL_W;
    localparam int SUM_W      = PROD_W + 1;

    localparam int TDATA_IN_W  = 112;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 16;
    localparam int TUSER_OUT_W = 1;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    localparam logic [ENT_W-1:0] ENT_NONE = {1'b1, {IDX_W{1'b0}}};
    localparam logic [CPU_W-1:0] CPU_RESET = 24'd65536;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_QUERY,
        OP_NEXT
    } t_opcode;

    typedef enum logic [2:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Z,
        REG_CELLS_PER_UNIT,
        REG_PAD_ZERO,
        REG_PAD_ONE
    } t_reg_idx;

    typedef enum logic [2:0] {
        CO_INS_X,
        CO_INS_Z,
        CO_MIN_X,
        CO_MIN_Z,
        CO_MAX_X,
        CO_MAX_Z
    } t_coord;

    typedef enum logic [1:0] {
        HR_INS,
        HR_QMIN,
        HR_ITER
    } t_hsel;

    typedef struct packed {
        logic   latch;
        logic   pad_en;
        logic   d_en;
        logic   mlo_en;
        logic   mhi_en;
        logic   fin_en;
        t_coord coord;
        logic   sweep_wr;
        logic   head_rd;
        t_hsel  hsel;
        logic   ins_wr;
        logic   q_set;
        logic   it_adv;
        logic   it_load;
        logic   link_rd;
        logic   it_pop;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    live;
        logic    sweep_last;
        logic    entry_none;
        logic    adv_done;
    } t_dp_st;

endpackage
`default_nettype wire

/* hw/rtl/grid_bucket_radius_query.sv */
// Next steps cell by cell until it finds an entry or the box runs out; a dead
// insert is skipped without touching the memories; clear empties one head entry per
// cycle over both classes.
// Throughput: one transaction at a time; a result waiting in the output register
// does not hold off the next transaction, only its delivery.
// Reset: synchronous, active low; afterwards a sweep empties all 8192 cell heads
// with s_tready low. Configuration writes are taken throughout.
`default_nettype none
module grid_bucket_radius_query (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // object_index[9:0], live[10], pos_x[42:11], pos_z[74:43], radius[106:75]
    input  wire [gbrq_pkg::TDATA_IN_W-1:0]    s_tdata,
    // opcode[1:0], object_class[2]
    input  wire [gbrq_pkg::TUSER_IN_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // found_index[9:0]
    output logic [gbrq_pkg::TDATA_OUT_W-1:0]  m_tdata,
    // found[0]
    output logic [gbrq_pkg::TUSER_OUT_W-1:0]  m_tuser,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [gbrq_pkg::PADDR_W-1:0]       paddr,
    input  wire [gbrq_pkg::PDATA_W-1:0]       pwdata,
    output logic [gbrq_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    gbrq_pkg::t_dp_cmd w_cmd;
    gbrq_pkg::t_dp_st  w_st;

    assign pready = 1'b1;

    gbrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (w_cmd),
        .i_st       (w_st)
    );

    gbrq_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_st      (w_st),
        .i_s_tuser (s_tuser),
        .i_s_tdata (s_tdata),
        .o_m_tuser (m_tuser),
        .o_m_tdata (m_tdata),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata)
    );

endmodule
`default_nettype wire

/* hw/rtl/gbrq_datapath.sv */
`default_nettype none
module gbrq_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  gbrq_pkg::t_dp_cmd                i_cmd,
    output gbrq_pkg::t_dp_st                 o_st,
    // opcode, object_class
    input  wire [gbrq_pkg::TUSER_IN_W-1:0]   i_s_tuser,
    // object_index, live, pos_x, pos_z, radius
    input  wire [gbrq_pkg::TDATA_IN_W-1:0]   i_s_tdata,
    // found
    output logic [gbrq_pkg::TUSER_OUT_W-1:0] o_m_tuser,
    // found_index
    output logic [gbrq_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    input  wire                              i_psel,
    input  wire                              i_penable,
    input  wire                              i_pwrite,
    input  wire [gbrq_pkg::PADDR_W-1:0]      i_paddr,
    input  wire [gbrq_pkg::PDATA_W-1:0]      i_pwdata,
    output logic [gbrq_pkg::PDATA_W-1:0]     o_prdata
);

    // configuration
    logic signed [gbrq_pkg::POS_W-1:0] r_origin_x;
    logic signed [gbrq_pkg::POS_W-1:0] r_origin_z;
    logic [gbrq_pkg::CPU_W-1:0]        r_cpu;
    logic [gbrq_pkg::PAD_W-1:0]        r_pad0;
    logic [gbrq_pkg::PAD_W-1:0]        r_pad1;
    gbrq_pkg::t_reg_idx                w_ridx;

    // latched transaction
    gbrq_pkg::t_opcode                 r_op;
    logic                              r_k;
    logic [gbrq_pkg::IDX_W-1:0]        r_oi;
    logic                              r_live;
    logic [gbrq_pkg::POS_W-1:0]        r_px;
    logic [gbrq_pkg::POS_W-1:0]        r_pz;
    logic [gbrq_pkg::POS_W-1:0]        r_rad;

    // cell arithmetic
    logic [gbrq_pkg::PADS_W-1:0]       r_pad;
    logic [gbrq_pkg::PADS_W-1:0]       n_pad;
    logic [gbrq_pkg::D_W-1:0]          r_d;
    logic [gbrq_pkg::D_W-1:0]          n_d;
    logic [gbrq_pkg::D_W-1:0]          w_p35;
    logic [gbrq_pkg::D_W-1:0]          w_o35;
    logic [gbrq_pkg::D_W-1:0]          w_pad35;
    logic [gbrq_pkg::DL_W-1:0]         w_mop;
    logic [gbrq_pkg::PROD_W-1:0]       w_prod;
    logic [gbrq_pkg::PROD_W-1:0]       r_plo;
    logic [gbrq_pkg::PROD_W-1:0]       r_phi;
    logic [gbrq_pkg::SUM_W-1:0]        w_sum;
    logic [gbrq_pkg::CELL_W-1:0]       w_cellv;
    logic [gbrq_pkg::CELL_W-1:0]       r_cx, r_cz, r_mnx, r_mnz, r_mxx, r_mxz;

    // memories
    logic [gbrq_pkg::ENT_W-1:0]        r_head_mem [gbrq_pkg::HEAD_DEPTH];
    logic [gbrq_pkg::ENT_W-1:0]        r_link_mem [gbrq_pkg::LINK_DEPTH];
    logic [gbrq_pkg::ENT_W-1:0]        r_head_q;
    logic [gbrq_pkg::ENT_W-1:0]        r_link_q;
    logic [gbrq_pkg::HEAD_AW-1:0]      r_sweep;
    logic [gbrq_pkg::HEAD_AW-1:0]      w_hraddr;
    logic [gbrq_pkg::HEAD_AW-1:0]      w_hins;

    // iterators, one per class
    logic [gbrq_pkg::CNT_W-1:0]        r_itx [2];
    logic [gbrq_pkg::CNT_W-1:0]        r_itz [2];
    logic [gbrq_pkg::CELL_W-1:0]       r_bmnx [2];
    logic [gbrq_pkg::CELL_W-1:0]       r_bmxx [2];
    logic [gbrq_pkg::CELL_W-1:0]       r_bmxz [2];
    logic [gbrq_pkg::ENT_W-1:0]        r_ent [2];
    logic [gbrq_pkg::CNT_W-1:0]        w_nx;
    logic [gbrq_pkg::CNT_W-1:0]        w_nz;
    logic                              w_xover;
    logic                              w_zover;

    // result stage and output register
    logic                              r_sf;
    logic [gbrq_pkg::IDX_W-1:0]        r_sidx;
    logic                              r_of;
    logic [gbrq_pkg::IDX_W-1:0]        r_oidx;

    assign w_ridx = gbrq_pkg::t_reg_idx'(i_paddr[gbrq_pkg::PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_z <= '0;
            r_cpu      <= gbrq_pkg::CPU_RESET;
            r_pad0     <= '0;
            r_pad1     <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            case (w_ridx)
                gbrq_pkg::REG_ORIGIN_X:       r_origin_x <= i_pwdata;
                gbrq_pkg::REG_ORIGIN_Z:       r_origin_z <= i_pwdata;
                gbrq_pkg::REG_CELLS_PER_UNIT: r_cpu <= i_pwdata[gbrq_pkg::CPU_W-1:0];
                gbrq_pkg::REG_PAD_ZERO:       r_pad0 <= i_pwdata[gbrq_pkg::PAD_W-1:0];
                gbrq_pkg::REG_PAD_ONE:        r_pad1 <= i_pwdata[gbrq_pkg::PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            gbrq_pkg::REG_ORIGIN_X:       o_prdata = r_origin_x;
            gbrq_pkg::REG_ORIGIN_Z:       o_prdata = r_origin_z;
            gbrq_pkg::REG_CELLS_PER_UNIT: o_prdata = {8'd0, r_cpu};
            gbrq_pkg::REG_PAD_ZERO:       o_prdata = {1'b0, r_pad0};
            gbrq_pkg::REG_PAD_ONE:        o_prdata = {1'b0, r_pad1};
            default:                      o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= gbrq_pkg::t_opcode'(i_s_tuser[1:0]);
            r_k    <= i_s_tuser[2];
            r_oi   <= i_s_tdata[9:0];
            r_live <= i_s_tdata[10];
            r_px   <= i_s_tdata[42:11];
            r_pz   <= i_s_tdata[74:43];
            r_rad  <= i_s_tdata[106:75];
        end
    end

    // pad: class pad plus a positive radius, else the negated radius
    always_comb begin
        if (!r_rad[gbrq_pkg::POS_W-1] && (|r_rad)) begin
            n_pad = {2'b00, (r_k ? r_pad1 : r_pad0)} + {1'b0, r_rad};
        end else begin
            n_pad = {gbrq_pkg::PADS_W{1'b0}} - {r_rad[gbrq_pkg::POS_W-1], r_rad};
        end
    end

    always_comb begin
        logic [gbrq_pkg::POS_W-1:0] v_p;
        logic [gbrq_pkg::POS_W-1:0] v_o;
        case (i_cmd.coord)
            gbrq_pkg::CO_INS_Z, gbrq_pkg::CO_MIN_Z, gbrq_pkg::CO_MAX_Z: begin
                v_p = r_pz;
                v_o = r_origin_z;
            end
            default: begin
                v_p = r_px;
                v_o = r_origin_x;
            end
        endcase
        w_p35   = {{3{v_p[gbrq_pkg::POS_W-1]}}, v_p};
        w_o35   = {{3{v_o[gbrq_pkg::POS_W-1]}}, v_o};
        w_pad35 = {2'b00, r_pad};
        case (i_cmd.coord)
            gbrq_pkg::CO_MIN_X, gbrq_pkg::CO_MIN_Z: n_d = w_p35 - w_pad35 - w_o35;
            gbrq_pkg::CO_MAX_X, gbrq_pkg::CO_MAX_Z: n_d = w_p35 + w_pad35 - w_o35;
            default:                                n_d = w_p35 - w_o35;
        endcase
    end

    // one shared multiplier, low half then high half of the offset
    assign w_mop  = i_cmd.mhi_en ? r_d[gbrq_pkg::D_W-2:gbrq_pkg::DL_W]
                                 : r_d[gbrq_pkg::DL_W-1:0];
    assign w_prod = w_mop * r_cpu;
    assign w_sum  = gbrq_pkg::SUM_W'(r_plo)
                  + gbrq_pkg::SUM_W'({r_phi[gbrq_pkg::SAT_LO-1:0], {gbrq_pkg::DL_W{1'b0}}});

    always_comb begin
        if (r_d[gbrq_pkg::D_W-1]) begin
            w_cellv = '0;
        end else if ((|r_phi[gbrq_pkg::PROD_W-1:gbrq_pkg::SAT_LO])
                     || (|w_sum[gbrq_pkg::SUM_W-1:gbrq_pkg::FRAC+gbrq_pkg::CELL_W])) begin
            w_cellv = {gbrq_pkg::CELL_W{1'b1}};
        end else begin
            w_cellv = w_sum[gbrq_pkg::FRAC+gbrq_pkg::CELL_W-1:gbrq_pkg::FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pad_en) begin
            r_pad <= n_pad;
        end
        if (i_cmd.d_en) begin
            r_d <= n_d;
        end
        if (i_cmd.mlo_en) begin
            r_plo <= w_prod;
        end
        if (i_cmd.mhi_en) begin
            r_phi <= w_prod;
        end
        if (i_cmd.fin_en) begin
            case (i_cmd.coord)
                gbrq_pkg::CO_INS_X: r_cx  <= w_cellv;
                gbrq_pkg::CO_INS_Z: r_cz  <= w_cellv;
                gbrq_pkg::CO_MIN_X: r_mnx <= w_cellv;
                gbrq_pkg::CO_MIN_Z: r_mnz <= w_cellv;
                gbrq_pkg::CO_MAX_X: r_mxx <= w_cellv;
                gbrq_pkg::CO_MAX_Z: r_mxz <= w_cellv;
                default: ;
            endcase
        end
    end

    assign w_hins = {r_k, r_cz, r_cx};

    always_comb begin
        case (i_cmd.hsel)
            gbrq_pkg::HR_QMIN: w_hraddr = {r_k, r_mnz, r_mnx};
            gbrq_pkg::HR_ITER: w_hraddr = {r_k, r_itz[r_k][gbrq_pkg::CELL_W-1:0],
                                           r_itx[r_k][gbrq_pkg::CELL_W-1:0]};
            default:           w_hraddr = w_hins;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_wr) begin
            r_head_mem[r_sweep] <= gbrq_pkg::ENT_NONE;
        end else if (i_cmd.ins_wr) begin
            r_head_mem[w_hins] <= {1'b0, r_oi};
        end
        if (i_cmd.head_rd) begin
            r_head_q <= r_head_mem[w_hraddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            r_link_mem[{r_k, r_oi}] <= r_head_q;
        end
        if (i_cmd.link_rd) begin
            r_link_q <= r_link_mem[{r_k, r_ent[r_k][gbrq_pkg::IDX_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep_wr) begin
            r_sweep <= r_sweep + 1'b1;
        end
    end

    // cell step, counters saturate at GRID_DIM
    assign w_nx    = (r_itx[r_k] >= gbrq_pkg::CNT_W'(gbrq_pkg::GRID_DIM))
                   ? gbrq_pkg::CNT_W'(gbrq_pkg::GRID_DIM) : r_itx[r_k] + 1'b1;
    assign w_nz    = (r_itz[r_k] >= gbrq_pkg::CNT_W'(gbrq_pkg::GRID_DIM))
                   ? gbrq_pkg::CNT_W'(gbrq_pkg::GRID_DIM) : r_itz[r_k] + 1'b1;
    assign w_xover = w_nx > {1'b0, r_bmxx[r_k]};
    assign w_zover = w_nz > {1'b0, r_bmxz[r_k]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_itx[i]  <= '0;
                r_itz[i]  <= '0;
                r_bmnx[i] <= '0;
                r_bmxx[i] <= '0;
                r_bmxz[i] <= '0;
                r_ent[i]  <= gbrq_pkg::ENT_NONE;
            end
        end else begin
            if (i_cmd.q_set) begin
                r_bmnx[r_k] <= r_mnx;
                r_bmxx[r_k] <= r_mxx;
                r_bmxz[r_k] <= r_mxz;
                r_itx[r_k]  <= {1'b0, r_mnx};
                r_itz[r_k]  <= {1'b0, r_mnz};
                r_ent[r_k]  <= r_head_q;
            end
            if (i_cmd.it_adv) begin
                if (w_xover) begin
                    r_itz[r_k] <= w_nz;
                    r_itx[r_k] <= w_zover ? w_nx : {1'b0, r_bmnx[r_k]};
                end else begin
                    r_itx[r_k] <= w_nx;
                end
            end
            if (i_cmd.it_load) begin
                r_ent[r_k] <= r_head_q;
            end
            if (i_cmd.it_pop) begin
                r_ent[r_k] <= r_link_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_sf   <= 1'b0;
            r_sidx <= '0;
        end else if (i_cmd.it_pop) begin
            r_sf   <= 1'b1;
            r_sidx <= r_ent[r_k][gbrq_pkg::IDX_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_of   <= r_sf;
            r_oidx <= r_sidx;
        end
    end

    assign o_m_tuser = r_of;
    assign o_m_tdata = {{(gbrq_pkg::TDATA_OUT_W - gbrq_pkg::IDX_W){1'b0}}, r_oidx};

    assign o_st.op         = r_op;
    assign o_st.live       = r_live;
    assign o_st.sweep_last = &r_sweep;
    assign o_st.entry_none = r_ent[r_k][gbrq_pkg::IDX_W];
    assign o_st.adv_done   = w_xover && w_zover;

endmodule
`default_nettype wire

/* hw/rtl/gbrq_ctrl.sv */
`default_nettype none
module gbrq_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output gbrq_pkg::t_dp_cmd   o_cmd,
    input  gbrq_pkg::t_dp_st    i_st
);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_DISP,
        S_PAD,
        S_DCALC,
        S_MLO,
        S_MHI,
        S_FIN,
        S_HREAD,
        S_INS,
        S_QSET,
        S_NCHK,
        S_NRDH,
        S_NLDH,
        S_NWL,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    gbrq_pkg::t_coord  r_coord, n_coord;
    logic              r_item, n_item;
    logic              r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.coord = r_coord;
        o_cmd.hsel  = gbrq_pkg::HR_INS;
        n_state     = r_state;
        n_coord     = r_coord;
        n_item      = r_item;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_st.sweep_last) begin
                    n_state = r_item ? S_DONE : S_IDLE;
                    n_item  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_st.op)
                    gbrq_pkg::OP_CLEAR: begin
                        n_item  = 1'b1;
                        n_state = S_SWEEP;
                    end
                    gbrq_pkg::OP_INSERT: begin
                        n_coord = gbrq_pkg::CO_INS_X;
                        n_state = i_st.live ? S_DCALC : S_DONE;
                    end
                    gbrq_pkg::OP_QUERY: n_state = S_PAD;
                    gbrq_pkg::OP_NEXT:  n_state = S_NCHK;
                    default:            n_state = S_DONE;
                endcase
            end
            S_PAD: begin
                o_cmd.pad_en = 1'b1;
                n_coord      = gbrq_pkg::CO_MIN_X;
                n_state      = S_DCALC;
            end
            S_DCALC: begin
                o_cmd.d_en = 1'b1;
                n_state    = S_MLO;
            end
            S_MLO: begin
                o_cmd.mlo_en = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mhi_en = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_en = 1'b1;
                n_state      = S_DCALC;
                case (r_coord)
                    gbrq_pkg::CO_INS_X: n_coord = gbrq_pkg::CO_INS_Z;
                    gbrq_pkg::CO_MIN_X: n_coord = gbrq_pkg::CO_MIN_Z;
                    gbrq_pkg::CO_MIN_Z: n_coord = gbrq_pkg::CO_MAX_X;
                    gbrq_pkg::CO_MAX_X: n_coord = gbrq_pkg::CO_MAX_Z;
                    default:            n_state = S_HREAD;
                endcase
            end
            S_HREAD: begin
                o_cmd.head_rd = 1'b1;
                if (i_st.op == gbrq_pkg::OP_INSERT) begin
                    n_state = S_INS;
                end else begin
                    o_cmd.hsel = gbrq_pkg::HR_QMIN;
                    n_state    = S_QSET;
                end
            end
            S_INS: begin
                o_cmd.ins_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_QSET: begin
                o_cmd.q_set = 1'b1;
                n_state     = S_DONE;
            end
            S_NCHK: begin
                if (!i_st.entry_none) begin
                    o_cmd.link_rd = 1'b1;
                    n_state       = S_NWL;
                end else begin
                    o_cmd.it_adv = 1'b1;
                    n_state      = i_st.adv_done ? S_DONE : S_NRDH;
                end
            end
            S_NRDH: begin
                o_cmd.head_rd = 1'b1;
                o_cmd.hsel    = gbrq_pkg::HR_ITER;
                n_state       = S_NLDH;
            end
            S_NLDH: begin
                o_cmd.it_load = 1'b1;
                n_state       = S_NCHK;
            end
            S_NWL: begin
                o_cmd.it_pop = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_coord     <= gbrq_pkg::CO_INS_X;
            r_item      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_coord     <= n_coord;
            r_item      <= n_item;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule
`default_nettype wire

/* hw/rtl/gbrq_checker.sv */
`default_nettype none
`include "grid_bucket_radius_query_macros.svh"
module gbrq_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_tvalid,
    input wire                              s_tready,
    input wire [gbrq_pkg::TDATA_IN_W-1:0]   s_tdata,
    input wire [gbrq_pkg::TUSER_IN_W-1:0]   s_tuser,
    input wire                              m_tvalid,
    input wire                              m_tready,
    input wire [gbrq_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input wire [gbrq_pkg::TUSER_OUT_W-1:0]  m_tuser,
    input wire                              psel,
    input wire                              penable,
    input wire                              pwrite,
    input wire [gbrq_pkg::PADDR_W-1:0]      paddr,
    input wire [gbrq_pkg::PDATA_W-1:0]      pwdata,
    input wire [gbrq_pkg::PDATA_W-1:0]      prdata,
    input wire                              pready
);

    `GBRQ_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `GBRQ_ASSERT(a_one_at_time, s_tvalid && s_tready |=> !s_tready, "second transaction taken early")
    `GBRQ_ASSERT(a_none_zero, m_tvalid && !m_tuser[0] |-> m_tdata == '0, "empty result carries index")
    `GBRQ_ASSERT_ALWAYS(a_reset_busy, !i_rst_n |=> !s_tready, "input open right after reset")
    `GBRQ_ASSERT(a_pready, pready, "pready low")

endmodule

bind grid_bucket_radius_query gbrq_checker u_gbrq_checker (.*);
`default_nettype wire

/* tb/grid_bucket_radius_query_tb.sv */
`default_nettype none
module grid_bucket_radius_query_tb;
    import gbrq_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        t_opcode     op;
        bit          cls;
        bit [9:0]    idx;
        bit          live;
        int          px;
        int          pz;
        int          rad;
    } t_cmd;

    typedef struct {
        bit          found;
        bit [9:0]    idx;
    } t_answer;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_tvalid = 1'b0;
    wire                     s_tready;
    logic [TDATA_IN_W-1:0]   s_tdata = '0;
    logic [TUSER_IN_W-1:0]   s_tuser = '0;
    wire                     m_tvalid;
    logic                    m_tready = 1'b0;
    wire  [TDATA_OUT_W-1:0]  m_tdata;
    wire  [TUSER_OUT_W-1:0]  m_tuser;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [PADDR_W-1:0]      paddr = '0;
    logic [PDATA_W-1:0]      pwdata = '0;
    wire  [PDATA_W-1:0]      prdata;
    wire                     pready;

    grid_bucket_radius_query dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // grid model
    int          org_x, org_z;
    int unsigned scale;
    int unsigned pad_k[2];
    int          heads[2][GRID_DIM][GRID_DIM];
    int          links[2][POOL_SIZE];
    int          it_x[2], it_z[2], bx_min[2], bx_max[2], bz_max[2], it_ent[2];

    t_cmd        pending_cmds[$];
    t_answer     expected_answers[$];
    t_cmd        cur;
    int          errors = 0;
    int          accepted = 0;
    longint      cycles = 0;
    bit          calm;

    assign calm = accepted >= 600 && accepted < 800;

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int bin_of(input longint d);
        longint unsigned c;
        if (d < 0) return 0;
        c = (longint'(d) * longint'(scale)) >> 24;
        if (c > GRID_DIM - 1) c = GRID_DIM - 1;
        return int'(c);
    endfunction

    function automatic void wipe_grid();
        foreach (heads[k, z, x]) heads[k][z][x] = -1;
    endfunction

    function automatic int walk_next(input int k);
        int e;
        int nx, nz;
        while (it_ent[k] < 0) begin
            nx = it_x[k] + 1;
            if (nx > GRID_DIM) nx = GRID_DIM;
            it_x[k] = nx;
            if (nx > bx_max[k]) begin
                nz = it_z[k] + 1;
                if (nz > GRID_DIM) nz = GRID_DIM;
                it_z[k] = nz;
                if (nz > bz_max[k]) return -1;
                it_x[k] = bx_min[k];
            end
            it_ent[k] = heads[k][it_z[k]][it_x[k]];
        end
        e = it_ent[k];
        it_ent[k] = links[k][e];
        return e;
    endfunction

    function automatic t_answer grid_step(input t_cmd c);
        t_answer a;
        int      k, cx, cz, e;
        longint  pad;
        a.found = 1'b0;
        a.idx = '0;
        k = c.cls;
        case (c.op)
            OP_CLEAR: wipe_grid();
            OP_INSERT: begin
                if (c.live) begin
                    cx = bin_of(longint'(c.px) - org_x);
                    cz = bin_of(longint'(c.pz) - org_z);
                    links[k][c.idx] = heads[k][cz][cx];
                    heads[k][cz][cx] = c.idx;
                end
            end
            OP_QUERY: begin
                if (c.rad > 0) pad = longint'(pad_k[k]) + c.rad;
                else pad = -longint'(c.rad);
                bx_min[k] = bin_of(longint'(c.px) - pad - org_x);
                it_z[k] = bin_of(longint'(c.pz) - pad - org_z);
                bx_max[k] = bin_of(longint'(c.px) + pad - org_x);
                bz_max[k] = bin_of(longint'(c.pz) + pad - org_z);
                it_x[k] = bx_min[k];
                it_ent[k] = heads[k][it_z[k]][it_x[k]];
            end
            OP_NEXT: begin
                e = walk_next(k);
                if (e >= 0) begin
                    a.found = 1'b1;
                    a.idx = e[9:0];
                end
            end
        endcase
        return a;
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(grid_step(cur));
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 31)) begin
                    cur = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, cur.rad, cur.pz, cur.px, cur.live, cur.idx};
                    s_tuser <= {cur.cls, cur.op};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    a = expected_answers.pop_front();
                    if (m_tuser[0] !== a.found)
                        report($sformatf("found %b, expected %b", m_tuser[0], a.found));
                    if (m_tdata[9:0] !== a.idx)
                        report($sformatf("index %0d, expected %0d", m_tdata[9:0], a.idx));
                end
            end
            m_tready <= calm || $urandom_range(0, 99) >= 31;
        end
    end

    task automatic add(input t_opcode op, input bit cls, input bit [9:0] idx, input bit live,
                       input int px, input int pz, input int rad);
        t_cmd c;
        c.op = op; c.cls = cls; c.idx = idx; c.live = live;
        c.px = px; c.pz = pz; c.rad = rad;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_tvalid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx r, input bit [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_ORIGIN_X:       org_x = v;
            REG_ORIGIN_Z:       org_z = v;
            REG_CELLS_PER_UNIT: scale = v[23:0];
            REG_PAD_ZERO:       pad_k[0] = v[30:0];
            REG_PAD_ONE:        pad_k[1] = v[30:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int ox, input int oz, input bit [23:0] cpu,
                              input bit [30:0] p0, input bit [30:0] p1);
        wait_idle();
        apb_write(REG_ORIGIN_X, ox);
        apb_write(REG_ORIGIN_Z, oz);
        apb_write(REG_CELLS_PER_UNIT, cpu);
        apb_write(REG_PAD_ZERO, p0);
        apb_write(REG_PAD_ONE, p1);
    endtask

    // mostly insert/query/drain sequences near one spot, some noise
    task automatic random_phase(input int n);
        longint span;
        int     bx, bz, cnt, k, sel;
        int     start;
        if (scale == 0) span = 4096;
        else span = (longint'(64) << 24) / scale;
        if (span > (1 << 28)) span = 1 << 28;
        if (span < 8) span = 8;
        start = pending_cmds.size();
        while (pending_cmds.size() - start < n) begin
            sel = $urandom_range(0, 99);
            k = $urandom_range(0, 1);
            if (sel < 1) begin
                add(OP_CLEAR, k, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (sel < 12) begin
                add(t_opcode'($urandom_range(1, 3)), k, $urandom, $urandom,
                    $urandom, $urandom,
                    $urandom_range(0, 3) == 0 ? int'($urandom) : int'($urandom_range(0, 64)));
            end else begin
                bx = org_x + int'($urandom_range(0, span)) - int'(span / 8);
                bz = org_z + int'($urandom_range(0, span)) - int'(span / 8);
                cnt = $urandom_range(1, 6);
                repeat (cnt)
                    add(OP_INSERT, k, $urandom, $urandom_range(0, 9) != 0,
                        bx + int'($urandom_range(0, span / 16)),
                        bz + int'($urandom_range(0, span / 16)), $urandom);
                add(OP_QUERY, k, $urandom, $urandom, bx, bz,
                    $urandom_range(0, 3) == 0 ? -int'($urandom_range(0, span / 16))
                                              : int'($urandom_range(0, span / 16)));
                repeat ($urandom_range(1, cnt + 3)) begin
                    if ($urandom_range(0, 49) == 0)
                        add(OP_CLEAR, k, 0, 0, 0, 0, 0);
                    add(OP_NEXT, k, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end
    endtask

    initial begin
        org_x = 0; org_z = 0; scale = 65536; pad_k[0] = 0; pad_k[1] = 0;
        wipe_grid();
        foreach (links[k, i]) links[k][i] = 0;
        foreach (it_x[k]) begin
            it_x[k] = 0; it_z[k] = 0; bx_min[k] = 0; bx_max[k] = 0; bz_max[k] = 0;
            it_ent[k] = -1;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // next before any query, extremes, loops, clear mid-query
        add(OP_NEXT, 0, 0, 0, 0, 0, 0);
        add(OP_NEXT, 1, 10'h3ff, 1, -1, -1, -1);
        add(OP_INSERT, 0, 10'd0, 1, 32'h7fffffff, 32'h7fffffff, 0);
        add(OP_INSERT, 0, 10'h3ff, 1, 32'h80000000, 32'h80000000, 0);
        add(OP_INSERT, 1, 10'd5, 0, 100, 100, 0);
        add(OP_INSERT, 1, 10'd7, 1, 300, 500, 0);
        add(OP_INSERT, 1, 10'd7, 1, 300, 500, 0);
        add(OP_QUERY, 0, 0, 0, 0, 0, 32'h80000000);
        add(OP_NEXT, 0, 0, 0, 0, 0, 0);
        add(OP_NEXT, 0, 0, 0, 0, 0, 0);
        add(OP_NEXT, 0, 0, 0, 0, 0, 0);
        add(OP_QUERY, 1, 0, 0, 300, 500, 0);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);
        add(OP_QUERY, 1, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);
        add(OP_CLEAR, 0, 0, 0, 0, 0, 0);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);
        add(OP_NEXT, 1, 0, 0, 0, 0, 0);

        set_config(-1000, -2000, 24'd65536, 31'd300, 31'd700);
        random_phase(400);
        set_config(32'h80000000, 32'h7fffffff, 24'hffffff, 31'h7fffffff, 31'h7fffffff);
        random_phase(250);
        set_config(0, 0, 24'd0, 31'd0, 31'd0);
        random_phase(150);
        set_config(5000, -3000, 24'd131072, 31'd128, 31'd0);
        random_phase(400);
        set_config(0, 0, 24'd32768, 31'd1000, 31'd50);
        random_phase(350);

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
